// ===== rtl/qenc_pkg.sv =====
// shared types, constants and helpers for the quadrature encoder counter
`default_nettype none

package qenc_pkg;

  localparam int COUNT_W = 13;
  localparam int REV_W = 32;
  localparam int CPR_W = 12;
  localparam int SPEED_W = 19;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic signed [REV_W-1:0] rev_t;
  typedef logic [CPR_W-1:0] cpr_t;
  typedef logic [SPEED_W-1:0] speed_t;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } pipe_en_t;

  localparam cpr_t CPR_RESET = 12'd2472;

  // speed = pulses * 500 / 103, saturating at SPEED_MAX
  localparam logic [8:0] SPEED_MUL = 9'd500;
  localparam speed_t SPEED_MAX = '1;
  // smallest pulse count whose quotient no longer fits the speed field
  localparam logic [32:0] SAT_PULSES = 33'd108004;
  localparam int PROD_W = 26;
  // reciprocal of 103 scaled by 2^33, exact for dividends below 2^26
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP = 27'd83397424;
  localparam int RECIP_SHIFT = 33;

  function automatic logic is_forward(input logic [1:0] prev, input logic [1:0] cur);
    logic fwd;
    fwd = (prev == 2'd0 && cur == 2'd2) || (prev == 2'd2 && cur == 2'd3) ||
          (prev == 2'd3 && cur == 2'd1) || (prev == 2'd1 && cur == 2'd0);
    return fwd;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quadrature_encoder_counter.sv =====
// quadrature encoder counter: x4 decoding, revolution tracking, speed sampling
//
// Input channel (in_valid/in_stall) carries op, chan_a, chan_b. An edge event
// (op = 0) steps the in-revolution count, wraps it at +/-counts_per_rev into
// the revolution counter and bumps a saturating pulse counter. A sample tick
// (op = 1) reports pulses * 500 / 103 and clears the pulse counter.
// Output channel (out_valid/out_stall) gives one result per input transfer,
// in order: count_in_rev, revolutions, speed, speed_valid.
// One item is taken every cycle while out_stall is not held, through the
// three-register pipeline (state update, pulse multiply, reciprocal
// multiply into the output register).
// When out_stall is held, items already inside fill the free stages and then
// in_stall rises; no result is lost or repeated.
// The counts_per_rev register is written over cfg_valid/cfg_ready/cfg_data;
// the user writes it only while the block is idle, which the block itself does not enforce; cfg_ready is always high.
// Synchronous reset clears all counters, the pipeline and sets
// counts_per_rev to 2472.
`default_nettype none

module quadrature_encoder_counter import qenc_pkg::*; #(
  parameter int PULSE_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                op,
  input  wire logic                chan_a,
  input  wire logic                chan_b,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [12:0]       count_in_rev,
  output logic signed [31:0]       revolutions,
  output logic [18:0]              speed,
  output logic                     speed_valid,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [11:0]         cfg_data
);

  cpr_t counts_per_rev;

  logic en1;
  pipe_en_t en;
  logic accept;
  op_t in_op;

  count_t count_next;
  rev_t rev_next;
  logic [PULSE_WIDTH-1:0] pulse;

  logic s1_valid;
  logic s2_valid;
  op_t s1_op;
  op_t s2_op;
  count_t s1_count;
  count_t s2_count;
  rev_t s1_rev;
  rev_t s2_rev;
  logic [PULSE_WIDTH-1:0] s1_pulse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      counts_per_rev <= cfg_data;
    end
  end

  assign en.s3 = !out_valid || !out_stall;
  assign en.s2 = !s2_valid || en.s3;
  assign en1 = !s1_valid || en.s2;
  assign in_stall = !en1;
  assign accept = in_valid && en1;
  assign in_op = op_t'(op);

  qenc_track #(
    .PULSE_WIDTH(PULSE_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (in_op),
    .chan_a    (chan_a),
    .chan_b    (chan_b),
    .cpr       (counts_per_rev),
    .count_next(count_next),
    .rev_next  (rev_next),
    .pulse     (pulse)
  );

  qenc_speed #(
    .PULSE_WIDTH(PULSE_WIDTH)
  ) u_speed (
    .clk   (clk),
    .en    (en),
    .sample(s1_op == OP_SAMPLE),
    .pulse (s1_pulse),
    .speed (speed)
  );

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_valid;
      end
      if (en.s2) begin
        s2_valid <= s1_valid;
      end
      if (en.s3) begin
        out_valid <= s2_valid;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op <= in_op;
      s1_count <= count_next;
      s1_rev <= rev_next;
      s1_pulse <= pulse;
    end
    if (en.s2) begin
      s2_op <= s1_op;
      s2_count <= s1_count;
      s2_rev <= s1_rev;
    end
    if (en.s3) begin
      count_in_rev <= s2_count;
      revolutions <= s2_rev;
      speed_valid <= (s2_op == OP_SAMPLE);
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid))
    else $error("input stalled with a free pipeline stage");

  a_edge_result_no_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !speed_valid) |-> (speed == '0))
    else $error("edge result carries a speed value");

  a_sample_clears_pulses: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_SAMPLE) |=> (pulse == '0))
    else $error("pulse counter not cleared by sample");

  a_pulse_saturates: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_EDGE && (&pulse)) |=> (&pulse))
    else $error("pulse counter wrapped");

endmodule

`default_nettype wire

// ===== rtl/qenc_track.sv =====
// phase decoder with in-revolution, revolution and pulse counters
`default_nettype none

module qenc_track import qenc_pkg::*; #(
  parameter int PULSE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire op_t                    op,
  input  wire logic                   chan_a,
  input  wire logic                   chan_b,
  input  wire cpr_t                   cpr,
  output count_t                      count_next,
  output rev_t                        rev_next,
  output logic [PULSE_WIDTH-1:0]      pulse
);

  logic [1:0] last_phase;
  count_t count;
  rev_t rev;

  logic [1:0] phase;
  logic signed [COUNT_W:0] stepped;
  logic signed [COUNT_W:0] limit;
  logic wrap_up;
  logic wrap_dn;
  logic [PULSE_WIDTH-1:0] pulse_next;

  always_comb begin
    phase = {chan_a, chan_b};
    stepped = {count[COUNT_W-1], count} +
              (is_forward(last_phase, phase) ? (COUNT_W+1)'(1) : '1);
    limit = $signed({2'b00, cpr});
    wrap_up = stepped >= limit;
    wrap_dn = stepped <= -limit;
    unique case (op)
      OP_EDGE: begin
        if (wrap_up) begin
          count_next = '0;
          rev_next = rev + REV_W'(1);
        end else if (wrap_dn) begin
          count_next = '0;
          rev_next = rev - REV_W'(1);
        end else begin
          count_next = stepped[COUNT_W-1:0];
          rev_next = rev;
        end
        pulse_next = (&pulse) ? pulse : pulse + PULSE_WIDTH'(1);
      end
      OP_SAMPLE: begin
        count_next = count;
        rev_next = rev;
        pulse_next = '0;
      end
      default: begin
        count_next = count;
        rev_next = rev;
        pulse_next = pulse;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= '0;
      count <= '0;
      rev <= '0;
      pulse <= '0;
    end else if (accept) begin
      if (op == OP_EDGE) begin
        last_phase <= phase;
      end
      count <= count_next;
      rev <= rev_next;
      pulse <= pulse_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qenc_speed.sv =====
// two-stage speed scaling: pulses * 500, then reciprocal multiply by 1/103
`default_nettype none

module qenc_speed import qenc_pkg::*; #(
  parameter int PULSE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire pipe_en_t               en,
  input  wire logic                   sample,
  input  wire logic [PULSE_WIDTH-1:0] pulse,
  output speed_t                      speed
);

  logic [32:0] pulse_ext;
  logic sample2;
  logic sat2;
  logic [PROD_W-1:0] prod2;
  logic [PROD_W+RECIP_W-1:0] full;

  assign pulse_ext = 33'(pulse);
  assign full = {{RECIP_W{1'b0}}, prod2} * {{PROD_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sample2 <= sample;
      sat2 <= pulse_ext >= SAT_PULSES;
      prod2 <= PROD_W'(pulse_ext[16:0]) * PROD_W'(SPEED_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (!sample2) begin
        speed <= '0;
      end else if (sat2) begin
        speed <= SPEED_MAX;
      end else begin
        speed <= full[RECIP_SHIFT +: SPEED_W];
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/quadrature_encoder_counter_tb.sv =====
// self-checking testbench for the quadrature encoder counter with its own decoding predictor
`default_nettype none

module quadrature_encoder_counter_tb;
  import qenc_pkg::*;

  localparam int PULSE_BITS = 16;
  localparam int SPEED_NUM = 500;
  localparam int SPEED_DEN = 103;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    op_t  op;
    logic a;
    logic b;
  } enc_event_t;

  typedef struct {
    count_t count;
    rev_t   revs;
    speed_t speed;
    logic   fresh;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic op = 1'b0;
  logic chan_a = 1'b0;
  logic chan_b = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  cpr_t cfg_data = '0;
  logic in_stall;
  logic out_valid;
  logic cfg_ready;
  logic signed [12:0] count_in_rev;
  logic signed [31:0] revolutions;
  logic [18:0] speed;
  logic speed_valid;

  quadrature_encoder_counter #(.PULSE_WIDTH(PULSE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .chan_a(chan_a),
    .chan_b(chan_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count_in_rev(count_in_rev),
    .revolutions(revolutions),
    .speed(speed),
    .speed_valid(speed_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  enc_event_t enc_events_q[$];
  reading_t expected_readings_q[$];
  enc_event_t cur_event;
  logic in_taken = 1'b0;
  logic no_gaps = 1'b0;
  logic [1:0] gen_phase = 2'd0;

  // predictor state
  cpr_t cpr_model = CPR_RESET;
  logic [1:0] phase_model = 2'd0;
  int count_model = 0;
  rev_t rev_model = '0;
  int unsigned pulse_model = 0;

  int errors = 0;
  int edge_total = 0;
  int tick_total = 0;
  int rev_steps = 0;
  int cfg_writes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic logic [1:0] next_phase(input logic [1:0] p, input logic fwd);
    case (p)
      2'd0: return fwd ? 2'd2 : 2'd1;
      2'd2: return fwd ? 2'd3 : 2'd0;
      2'd3: return fwd ? 2'd1 : 2'd2;
      default: return fwd ? 2'd0 : 2'd3;
    endcase
  endfunction

  function automatic reading_t predict_reading(input enc_event_t ev);
    reading_t r;
    logic [1:0] cur;
    int lim;
    longint q;
    r.speed = '0;
    r.fresh = 1'b0;
    if (ev.op == OP_EDGE) begin
      cur = {ev.a, ev.b};
      lim = int'(cpr_model);
      if (next_phase(phase_model, 1'b1) == cur) count_model++;
      else count_model--;
      phase_model = cur;
      if (pulse_model < (1 << PULSE_BITS) - 1) pulse_model++;
      if (count_model >= lim) begin
        count_model = 0;
        rev_model = rev_model + 1;
        rev_steps++;
      end else if (count_model <= -lim) begin
        count_model = 0;
        rev_model = rev_model - 1;
        rev_steps++;
      end
      edge_total++;
    end else begin
      q = longint'(pulse_model) * SPEED_NUM / SPEED_DEN;
      r.speed = (q > longint'(SPEED_MAX)) ? SPEED_MAX : speed_t'(q);
      pulse_model = 0;
      r.fresh = 1'b1;
      tick_total++;
    end
    r.count = count_t'(count_model);
    r.revs = rev_model;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (enc_events_q.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
        cur_event = enc_events_q.pop_front();
        op <= cur_event.op;
        chan_a <= cur_event.a;
        chan_b <= cur_event.b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !no_gaps && ($urandom_range(99) < 34);
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        cpr_model = cfg_data;
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        expected_readings_q.push_back(predict_reading(cur_event));
      end
      if (out_valid && !out_stall) begin
        if (expected_readings_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_readings_q.pop_front();
          if (count_in_rev !== want.count)
            report_mismatch($sformatf("count_in_rev %0d, expected %0d", count_in_rev, want.count));
          if (revolutions !== want.revs)
            report_mismatch($sformatf("revolutions %0d, expected %0d", revolutions, want.revs));
          if (speed !== want.speed)
            report_mismatch($sformatf("speed %0d, expected %0d", speed, want.speed));
          if (speed_valid !== want.fresh)
            report_mismatch($sformatf("speed_valid %b, expected %b", speed_valid, want.fresh));
        end
      end
    end
  end

  task automatic push_edge(input logic a, input logic b);
    enc_event_t ev;
    ev.op = OP_EDGE;
    ev.a = a;
    ev.b = b;
    enc_events_q.push_back(ev);
    gen_phase = {a, b};
  endtask

  task automatic push_sample();
    enc_event_t ev;
    ev.op = OP_SAMPLE;
    ev.a = 1'($urandom_range(1));
    ev.b = 1'($urandom_range(1));
    enc_events_q.push_back(ev);
  endtask

  task automatic push_steps(input int n, input logic fwd);
    logic [1:0] nxt;
    repeat (n) begin
      nxt = next_phase(gen_phase, fwd);
      push_edge(nxt[1], nxt[0]);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (enc_events_q.size() != 0 || in_valid || expected_readings_q.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cpr(input cpr_t v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly legal steps with sticky direction, some ticks and some bad phases
  task automatic random_burst(input int n);
    logic fwd;
    int r;
    fwd = 1'($urandom_range(1));
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        push_sample();
      end else if (r < 20) begin
        push_edge(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        if (r < 28) fwd = ~fwd;
        push_steps(1, fwd);
      end
    end
  endtask

  initial begin
    cpr_t settings[8];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one full cycle each way, unchanged and skipped phases, ticks
    push_sample();
    push_steps(4, 1'b1);
    push_edge(1'b0, 1'b0);
    push_edge(1'b1, 1'b1);
    push_steps(4, 1'b0);
    push_edge(1'b0, 1'b1);
    push_sample();
    push_sample();
    drain();

    // run without gaps on a short revolution: wraps both ways
    write_cpr(12'd50);
    no_gaps = 1'b1;
    push_steps(200, 1'b1);
    push_steps(200, 1'b0);
    push_sample();
    push_sample();
    drain();
    no_gaps = 1'b0;

    // count left beyond a lowered limit
    write_cpr(12'd4095);
    push_steps(120, 1'b1);
    drain();
    write_cpr(12'd100);
    push_steps(1, 1'b0);
    push_steps(2, 1'b1);
    drain();
    write_cpr(12'd4095);
    push_steps(120, 1'b0);
    drain();
    write_cpr(12'd100);
    push_steps(1, 1'b1);
    push_steps(2, 1'b0);
    drain();

    // limits of zero and one wrap on every edge
    write_cpr(12'd0);
    push_steps(3, 1'b1);
    push_steps(3, 1'b0);
    push_sample();
    drain();
    write_cpr(12'd1);
    push_steps(3, 1'b1);
    push_steps(3, 1'b0);
    push_edge(gen_phase[1], gen_phase[0]);
    push_sample();
    drain();

    settings[0] = 12'd4095;
    settings[1] = 12'd2;
    settings[2] = 12'd0;
    settings[3] = 12'd1;
    settings[4] = 12'd7;
    settings[5] = cpr_t'($urandom_range(4095, 2));
    settings[6] = CPR_RESET;
    settings[7] = cpr_t'($urandom_range(64, 2));
    foreach (settings[i]) begin
      write_cpr(settings[i]);
      random_burst(70);
      drain();
    end

    repeat (10) @(posedge clk);
    while (expected_readings_q.size() != 0) begin
      report_mismatch("expected result never arrived");
      void'(expected_readings_q.pop_front());
    end

    $display("covered %0d edge events and %0d speed ticks, %0d revolution steps",
             edge_total, tick_total, rev_steps);
    $display("over %0d counts_per_rev writes, with random gaps and stalls on both sides",
             cfg_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
